/* sv/vtyp_pkg.sv */
// Shared constants, tangent tables and types for the vector to yaw and pitch unit.
package vtyp_pkg;

	localparam int DEG_COUNT = 90;
	localparam int IDX_W     = 7;
	localparam int ANG_W     = 9;
	localparam int PITCH_W   = 10;
	localparam int OUT_W     = ((PITCH_W + ANG_W + 7) / 8) * 8;

	localparam int TANK_W    = 30;
	localparam int TSQ_W     = 59;
	localparam int TSQ_LO_W  = 30;
	localparam int TSQ_HI_W  = TSQ_W - TSQ_LO_W;

	localparam int TSCALE_W  = 24;
	localparam logic [TSCALE_W-1:0] TSCALE = 24'd10000000;

	localparam int SQS_W     = 47;
	localparam int SQS_LO_W  = 24;
	localparam int SQS_HI_W  = SQS_W - SQS_LO_W;
	localparam logic [SQS_W-1:0]    TSCALE_SQ = 47'd100000000000000;
	localparam logic [SQS_LO_W-1:0] SQS_LO = TSCALE_SQ[SQS_LO_W-1:0];
	localparam logic [SQS_HI_W-1:0] SQS_HI = TSCALE_SQ[SQS_W-1:SQS_LO_W];

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ANG_W-1:0] ang_t;

	localparam idx_t DEG_LAST  = 7'd89;
	localparam ang_t DEG_RIGHT = 9'd90;
	localparam ang_t DEG_HALF  = 9'd180;
	localparam ang_t DEG_FULL  = 9'd360;
	localparam ang_t DEG_UP    = 9'd90;
	localparam ang_t DEG_DOWN  = 9'd270;

	typedef logic [TANK_W-1:0] tank_tab_t [DEG_COUNT];
	typedef logic [TSQ_W-1:0]  tsq_tab_t  [DEG_COUNT];

	// Entry k is round(tan(k degrees) * 10^7), the lower boundary of degree k.
	localparam tank_tab_t TANK = '{
		30'd0, 30'd174551, 30'd349208, 30'd524078, 30'd699268, 30'd874887,
		30'd1051042, 30'd1227846, 30'd1405408, 30'd1583844, 30'd1763270,
		30'd1943803, 30'd2125566, 30'd2308682, 30'd2493280, 30'd2679492,
		30'd2867454, 30'd3057307, 30'd3249197, 30'd3443276, 30'd3639702,
		30'd3838640, 30'd4040262, 30'd4244748, 30'd4452287, 30'd4663077,
		30'd4877326, 30'd5095254, 30'd5317094, 30'd5543091, 30'd5773503,
		30'd6008606, 30'd6248694, 30'd6494076, 30'd6745085, 30'd7002075,
		30'd7265425, 30'd7535541, 30'd7812856, 30'd8097840, 30'd8390996,
		30'd8692867, 30'd9004040, 30'd9325151, 30'd9656888, 30'd10000000,
		30'd10355303, 30'd10723687, 30'd11106125, 30'd11503684, 30'd11917536,
		30'd12348972, 30'd12799416, 30'd13270448, 30'd13763819, 30'd14281480,
		30'd14825610, 30'd15398650, 30'd16003345, 30'd16642795, 30'd17320508,
		30'd18040478, 30'd18807265, 30'd19626105, 30'd20503038, 30'd21445069,
		30'd22460368, 30'd23558524, 30'd24750869, 30'd26050891, 30'd27474774,
		30'd29042109, 30'd30776835, 30'd32708526, 30'd34874144, 30'd37320508,
		30'd40107809, 30'd43314759, 30'd47046301, 30'd51445540, 30'd56712818,
		30'd63137515, 30'd71153697, 30'd81443464, 30'd95143645, 30'd114300523,
		30'd143006663, 30'd190811367, 30'd286362533, 30'd572899616
	};

	function automatic tsq_tab_t tsq_build();
		tsq_tab_t t;
		logic [2*TANK_W-1:0] p;
		for (int k = 0; k < DEG_COUNT; k++) begin
			p = (2*TANK_W)'(TANK[k]) * (2*TANK_W)'(TANK[k]);
			t[k] = p[TSQ_W-1:0];
		end
		return t;
	endfunction

	localparam tsq_tab_t TANK_SQ = tsq_build();

	typedef struct packed {
		logic vert;
		logic z_pos;
		logic z_neg;
		logic x_neg;
		logic y_neg;
	} flags_t;

endpackage

/* sv/vtyp_prep.sv */
// Front stages: magnitudes, squares and the scaled right-hand sides of both searches.
module vtyp_prep import vtyp_pkg::*; #(
	parameter int COMP_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           prev_valid,
	output logic                           prev_ready,
	input  logic signed [COMP_BITS-1:0]    x_comp,
	input  logic signed [COMP_BITS-1:0]    y_comp,
	input  logic signed [COMP_BITS-1:0]    z_comp,
	output logic                           next_valid,
	input  logic                           next_ready,
	output flags_t                         next_flags,
	output logic [COMP_BITS-1:0]           next_ax,
	output logic [COMP_BITS+TSCALE_W-1:0]  next_rhs_y,
	output logic [2*COMP_BITS-1:0]         next_s,
	output logic [2*COMP_BITS+SQS_W-1:0]   next_rhs_p
);

	localparam int C    = COMP_BITS;
	localparam int SQ_W = 2 * C;
	localparam int RY_W = C + TSCALE_W;
	localparam int RP_W = SQ_W + SQS_W;
	localparam int PH_W = C + SQS_HI_W;
	localparam int PL_W = C + SQS_LO_W;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [C-1:0] ax_nx, ay_nx, az_nx;
	flags_t       flags_nx;

	flags_t       flags_s1, flags_s2, flags_s3, flags_s4;
	logic [C-1:0] ax_s1, ay_s1, az_s1;
	logic [C-1:0] ax_s2, ax_s3, ax_s4;
	logic [SQ_W-1:0] axsq_s2, aysq_s2, azsq_s2;
	logic [RY_W-1:0] rhs_y_s2, rhs_y_s3, rhs_y_s4;
	logic [SQ_W-1:0] s_s3, s_s4;
	logic [PH_W-1:0] phh_s3, plh_s3;
	logic [PL_W-1:0] phl_s3, pll_s3;
	logic [RP_W-1:0] rhs_p_s4;
	logic [C-1:0]    zz_hi, zz_lo;

	assign rdy_s4     = !v_s4 || next_ready;
	assign rdy_s3     = !v_s3 || rdy_s4;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign prev_ready = rdy_s1;

	always_comb begin
		ax_nx = x_comp[C-1] ? $unsigned(-x_comp) : $unsigned(x_comp);
		ay_nx = y_comp[C-1] ? $unsigned(-y_comp) : $unsigned(y_comp);
		az_nx = z_comp[C-1] ? $unsigned(-z_comp) : $unsigned(z_comp);
		flags_nx.vert  = (x_comp == '0) && (y_comp == '0);
		flags_nx.z_pos = !z_comp[C-1] && (z_comp != '0);
		flags_nx.z_neg = z_comp[C-1];
		flags_nx.x_neg = x_comp[C-1];
		flags_nx.y_neg = y_comp[C-1];
	end

	assign zz_hi = azsq_s2[SQ_W-1:C];
	assign zz_lo = azsq_s2[C-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= prev_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ax_s1    <= ax_nx;
			ay_s1    <= ay_nx;
			az_s1    <= az_nx;
			flags_s1 <= flags_nx;
		end
		if (rdy_s2) begin
			ax_s2    <= ax_s1;
			flags_s2 <= flags_s1;
			axsq_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			aysq_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			azsq_s2  <= SQ_W'(az_s1) * SQ_W'(az_s1);
			rhs_y_s2 <= RY_W'(ay_s1) * RY_W'(TSCALE);
		end
		if (rdy_s3) begin
			ax_s3    <= ax_s2;
			flags_s3 <= flags_s2;
			rhs_y_s3 <= rhs_y_s2;
			s_s3     <= axsq_s2 + aysq_s2;
			phh_s3   <= PH_W'(zz_hi) * PH_W'(SQS_HI);
			phl_s3   <= PL_W'(zz_hi) * PL_W'(SQS_LO);
			plh_s3   <= PH_W'(zz_lo) * PH_W'(SQS_HI);
			pll_s3   <= PL_W'(zz_lo) * PL_W'(SQS_LO);
		end
		if (rdy_s4) begin
			ax_s4    <= ax_s3;
			flags_s4 <= flags_s3;
			rhs_y_s4 <= rhs_y_s3;
			s_s4     <= s_s3;
			rhs_p_s4 <= (RP_W'(phh_s3) << (C + SQS_LO_W)) + (RP_W'(phl_s3) << C)
				+ (RP_W'(plh_s3) << SQS_LO_W) + RP_W'(pll_s3);
		end
	end

	assign next_valid = v_s4;
	assign next_flags = flags_s4;
	assign next_ax    = ax_s4;
	assign next_rhs_y = rhs_y_s4;
	assign next_s     = s_s4;
	assign next_rhs_p = rhs_p_s4;

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		prev_valid && prev_ready |=> v_s1)
		else $error("accepted item did not enter the first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy_s3 |=> v_s3 && $stable(s_s3))
		else $error("stalled stage lost or changed its item");

endmodule

/* sv/vtyp_step.sv */
// One binary-search step over the degree boundaries for yaw and pitch, two stages deep.
module vtyp_step import vtyp_pkg::*; #(
	parameter int COMP_BITS = 24,
	parameter int BIT       = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           prev_valid,
	output logic                           prev_ready,
	input  flags_t                         prev_flags,
	input  logic [COMP_BITS-1:0]           prev_ax,
	input  logic [COMP_BITS+TSCALE_W-1:0]  prev_rhs_y,
	input  logic [2*COMP_BITS-1:0]         prev_s,
	input  logic [2*COMP_BITS+SQS_W-1:0]   prev_rhs_p,
	input  idx_t                           prev_ny,
	input  idx_t                           prev_np,
	output logic                           next_valid,
	input  logic                           next_ready,
	output flags_t                         next_flags,
	output logic [COMP_BITS-1:0]           next_ax,
	output logic [COMP_BITS+TSCALE_W-1:0]  next_rhs_y,
	output logic [2*COMP_BITS-1:0]         next_s,
	output logic [2*COMP_BITS+SQS_W-1:0]   next_rhs_p,
	output idx_t                           next_ny,
	output idx_t                           next_np
);

	localparam int C    = COMP_BITS;
	localparam int SQ_W = 2 * C;
	localparam int RY_W = C + TSCALE_W;
	localparam int RP_W = SQ_W + SQS_W;
	localparam int PY_W = TANK_W + C;
	localparam int PP_W = TSQ_W + SQ_W;
	localparam int HI_W = TSQ_HI_W + C;
	localparam int LO_W = TSQ_LO_W + C;
	localparam idx_t STEP     = idx_t'(1 << BIT);
	localparam idx_t LOW_MASK = idx_t'((1 << BIT) - 1);

	logic rdy_s1, rdy_s2;
	logic v_s1, v_s2;

	idx_t cy, cp, iy, ip;
	logic oky, okp;
	logic [TSQ_W-1:0] tsq;

	flags_t          flags_s1, flags_s2;
	logic [C-1:0]    ax_s1, ax_s2;
	logic [RY_W-1:0] rhs_y_s1, rhs_y_s2;
	logic [SQ_W-1:0] s_s1, s_s2;
	logic [RP_W-1:0] rhs_p_s1, rhs_p_s2;
	idx_t            ny_s1, np_s1, ny_s2, np_s2;
	logic            oky_s1, okp_s1;
	logic [PY_W-1:0] prody_s1;
	logic [HI_W-1:0] phh_s1, phl_s1;
	logic [LO_W-1:0] plh_s1, pll_s1;

	logic [PP_W-1:0] prodp;
	logic            le_y, le_p;

	assign rdy_s2     = !v_s2 || next_ready;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign prev_ready = rdy_s1;

	always_comb begin
		cy  = prev_ny | STEP;
		cp  = prev_np | STEP;
		oky = cy <= DEG_LAST;
		okp = cp <= DEG_LAST;
		iy  = oky ? cy : '0;
		ip  = okp ? cp : '0;
		tsq = TANK_SQ[ip];
	end

	always_comb begin
		prodp = (PP_W'(phh_s1) << (TSQ_LO_W + C)) + (PP_W'(phl_s1) << TSQ_LO_W)
			+ (PP_W'(plh_s1) << C) + PP_W'(pll_s1);
		le_y  = oky_s1 && (prody_s1 <= PY_W'(rhs_y_s1));
		le_p  = okp_s1 && (prodp <= PP_W'(rhs_p_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= prev_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			flags_s1 <= prev_flags;
			ax_s1    <= prev_ax;
			rhs_y_s1 <= prev_rhs_y;
			s_s1     <= prev_s;
			rhs_p_s1 <= prev_rhs_p;
			ny_s1    <= prev_ny;
			np_s1    <= prev_np;
			oky_s1   <= oky;
			okp_s1   <= okp;
			prody_s1 <= PY_W'(TANK[iy]) * PY_W'(prev_ax);
			phh_s1   <= HI_W'(tsq[TSQ_W-1:TSQ_LO_W]) * HI_W'(prev_s[SQ_W-1:C]);
			phl_s1   <= HI_W'(tsq[TSQ_W-1:TSQ_LO_W]) * HI_W'(prev_s[C-1:0]);
			plh_s1   <= LO_W'(tsq[TSQ_LO_W-1:0]) * LO_W'(prev_s[SQ_W-1:C]);
			pll_s1   <= LO_W'(tsq[TSQ_LO_W-1:0]) * LO_W'(prev_s[C-1:0]);
		end
		if (rdy_s2) begin
			flags_s2 <= flags_s1;
			ax_s2    <= ax_s1;
			rhs_y_s2 <= rhs_y_s1;
			s_s2     <= s_s1;
			rhs_p_s2 <= rhs_p_s1;
			ny_s2    <= le_y ? (ny_s1 | STEP) : ny_s1;
			np_s2    <= le_p ? (np_s1 | STEP) : np_s1;
		end
	end

	assign next_valid = v_s2;
	assign next_flags = flags_s2;
	assign next_ax    = ax_s2;
	assign next_rhs_y = rhs_y_s2;
	assign next_s     = s_s2;
	assign next_rhs_p = rhs_p_s2;
	assign next_ny    = ny_s2;
	assign next_np    = np_s2;

	a_low_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((ny_s2 & LOW_MASK) == '0) && ((np_s2 & LOW_MASK) == '0))
		else $error("search step decided a bit below its own");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (ny_s2 <= DEG_LAST) && (np_s2 <= DEG_LAST))
		else $error("search index beyond the last degree boundary");

endmodule

/* sv/vtyp_finish.sv */
// Back stages: boundary equality test for yaw, quadrant unfolding and the output register.
module vtyp_finish import vtyp_pkg::*; #(
	parameter int COMP_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           prev_valid,
	output logic                           prev_ready,
	input  flags_t                         prev_flags,
	input  logic [COMP_BITS-1:0]           prev_ax,
	input  logic [COMP_BITS+TSCALE_W-1:0]  prev_rhs_y,
	input  idx_t                           prev_ny,
	input  idx_t                           prev_np,
	output logic                           next_valid,
	input  logic                           next_ready,
	output logic signed [PITCH_W-1:0]      pitch_neg,
	output logic [ANG_W-1:0]               yaw_deg
);

	localparam int C    = COMP_BITS;
	localparam int RY_W = C + TSCALE_W;
	localparam int PY_W = TANK_W + C;

	logic rdy_s1, rdy_s2;
	logic v_s1, v_s2;

	flags_t          flags_s1;
	logic            ax_zero_s1;
	logic [RY_W-1:0] rhs_y_s1;
	logic [PY_W-1:0] prod_s1;
	idx_t            ny_s1, np_s1;

	logic exact;
	ang_t f, mag, yaw_nx, p, pitch_nx;
	ang_t yaw_s2, pitch_s2;

	assign rdy_s2     = !v_s2 || next_ready;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign prev_ready = rdy_s1;

	always_comb begin
		exact = ax_zero_s1 || (prod_s1 == PY_W'(rhs_y_s1));
		f     = ax_zero_s1 ? DEG_RIGHT : ANG_W'(ny_s1);
		if (!flags_s1.x_neg) begin
			mag = f;
		end else if (exact) begin
			mag = DEG_HALF - f;
		end else begin
			mag = DEG_HALF - f - ANG_W'(1);
		end
		p = ANG_W'(np_s1);
		if (flags_s1.vert) begin
			yaw_nx   = '0;
			pitch_nx = flags_s1.z_pos ? DEG_UP : DEG_DOWN;
		end else begin
			yaw_nx   = (flags_s1.y_neg && (mag != '0)) ? DEG_FULL - mag : mag;
			pitch_nx = (flags_s1.z_neg && (p != '0)) ? DEG_FULL - p : p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= prev_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			flags_s1   <= prev_flags;
			ax_zero_s1 <= prev_ax == '0;
			rhs_y_s1   <= prev_rhs_y;
			ny_s1      <= prev_ny;
			np_s1      <= prev_np;
			prod_s1    <= PY_W'(TANK[prev_ny]) * PY_W'(prev_ax);
		end
		if (rdy_s2) begin
			yaw_s2   <= yaw_nx;
			pitch_s2 <= pitch_nx;
		end
	end

	assign next_valid = v_s2;
	assign yaw_deg    = yaw_s2;
	assign pitch_neg  = PITCH_W'(0) - PITCH_W'(pitch_s2);

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> yaw_s2 < DEG_FULL)
		else $error("yaw outside a full turn");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> pitch_s2 < DEG_FULL)
		else $error("pitch outside a full turn");

endmodule

/* sv/vector_to_yaw_pitch_unit.sv */
// Top level of the vector to yaw and pitch unit: front stages, search steps and back stages.
// Each item is a signed direction vector and yields one item holding whole-degree yaw and
// negated pitch. A new item is taken in every cycle while the output is not stalled, and
// each item passes through twenty register stages: four front stages form magnitudes,
// squares and scaled sums, seven search steps of two stages each find the degree boundary
// by a binary search over the tangent table, and two back stages test for an exact boundary
// and unfold the quadrants.
// Every stage has its own valid bit and ready, so a stall on the output only backs up as far
// as the pipeline is full and empty stages keep taking items.
module vector_to_yaw_pitch_unit import vtyp_pkg::*; #(
	parameter int COMP_BITS = 24,
	localparam int IN_W = ((3 * COMP_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// x_comp, y_comp, z_comp, each COMP_BITS wide, then zero padding.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// pitch_neg (10 bits), yaw_deg (9 bits), then zero padding.
	output logic [OUT_W-1:0] m_tdata
);

	localparam int C     = COMP_BITS;
	localparam int SQ_W  = 2 * C;
	localparam int RY_W  = C + TSCALE_W;
	localparam int RP_W  = SQ_W + SQS_W;
	localparam int STEPS = IDX_W;

	logic            v_c     [STEPS+1];
	logic            rdy_c   [STEPS+1];
	flags_t          flags_c [STEPS+1];
	logic [C-1:0]    ax_c    [STEPS+1];
	logic [RY_W-1:0] rhs_y_c [STEPS+1];
	logic [SQ_W-1:0] s_c     [STEPS+1];
	logic [RP_W-1:0] rhs_p_c [STEPS+1];
	idx_t            ny_c    [STEPS+1];
	idx_t            np_c    [STEPS+1];

	logic signed [PITCH_W-1:0] pitch_neg;
	logic [ANG_W-1:0]          yaw_deg;

	assign ny_c[0] = '0;
	assign np_c[0] = '0;

	vtyp_prep #(
		.COMP_BITS(C)
	) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (s_tvalid),
		.prev_ready (s_tready),
		.x_comp     (s_tdata[C-1:0]),
		.y_comp     (s_tdata[2*C-1:C]),
		.z_comp     (s_tdata[3*C-1:2*C]),
		.next_valid (v_c[0]),
		.next_ready (rdy_c[0]),
		.next_flags (flags_c[0]),
		.next_ax    (ax_c[0]),
		.next_rhs_y (rhs_y_c[0]),
		.next_s     (s_c[0]),
		.next_rhs_p (rhs_p_c[0])
	);

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		vtyp_step #(
			.COMP_BITS(C),
			.BIT      (STEPS - 1 - g)
		) u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (v_c[g]),
			.prev_ready (rdy_c[g]),
			.prev_flags (flags_c[g]),
			.prev_ax    (ax_c[g]),
			.prev_rhs_y (rhs_y_c[g]),
			.prev_s     (s_c[g]),
			.prev_rhs_p (rhs_p_c[g]),
			.prev_ny    (ny_c[g]),
			.prev_np    (np_c[g]),
			.next_valid (v_c[g+1]),
			.next_ready (rdy_c[g+1]),
			.next_flags (flags_c[g+1]),
			.next_ax    (ax_c[g+1]),
			.next_rhs_y (rhs_y_c[g+1]),
			.next_s     (s_c[g+1]),
			.next_rhs_p (rhs_p_c[g+1]),
			.next_ny    (ny_c[g+1]),
			.next_np    (np_c[g+1])
		);
	end

	vtyp_finish #(
		.COMP_BITS(C)
	) u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (v_c[STEPS]),
		.prev_ready (rdy_c[STEPS]),
		.prev_flags (flags_c[STEPS]),
		.prev_ax    (ax_c[STEPS]),
		.prev_rhs_y (rhs_y_c[STEPS]),
		.prev_ny    (ny_c[STEPS]),
		.prev_np    (np_c[STEPS]),
		.next_valid (m_tvalid),
		.next_ready (m_tready),
		.pitch_neg  (pitch_neg),
		.yaw_deg    (yaw_deg)
	);

	assign m_tdata = OUT_W'({yaw_deg, pitch_neg});

endmodule

/* tb/sv/tb_vector_to_yaw_pitch_unit.sv */
// Self-checking testbench for the vector to yaw and pitch unit, with its own angle predictor.
module tb_vector_to_yaw_pitch_unit;
	import vtyp_pkg::*;

	localparam int COMP_W     = 24;
	localparam int IN_W       = ((3 * COMP_W + 7) / 8) * 8;
	localparam int RAND_ITEMS = 1450;
	localparam int DRAIN      = 40;
	localparam int LIMIT      = 200000;
	localparam int MAX_PRINTS = 20;

	localparam logic signed [COMP_W-1:0] CMAX = 24'h7FFFFF;
	localparam logic signed [COMP_W-1:0] CMIN = 24'h800000;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch_neg;
		logic [ANG_W-1:0]          yaw_deg;
	} angle_t;

	typedef struct {
		comp_t                     x;
		comp_t                     y;
		comp_t                     z;
		bit                        known;
		logic signed [PITCH_W-1:0] pitch_neg;
		logic [ANG_W-1:0]          yaw_deg;
	} vec_case_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	angle_t pending_angles[$];
	int     errors       = 0;
	int     results_seen = 0;
	int     cycle_count  = 0;
	int     src_idle;
	int     snk_idle;

	vec_case_t plan[24] = '{
		'{24'sd0, 24'sd0, 24'sd0, 1'b1, -10'sd270, 9'd0},
		'{24'sd0, 24'sd0, 24'sd1, 1'b1, -10'sd90, 9'd0},
		'{24'sd0, 24'sd0, -24'sd1, 1'b1, -10'sd270, 9'd0},
		'{24'sd0, 24'sd0, CMAX, 1'b1, -10'sd90, 9'd0},
		'{24'sd0, 24'sd0, CMIN, 1'b1, -10'sd270, 9'd0},
		'{24'sd1, 24'sd0, 24'sd0, 1'b1, 10'sd0, 9'd0},
		'{-24'sd1, 24'sd0, 24'sd0, 1'b1, 10'sd0, 9'd180},
		'{24'sd0, 24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd90},
		'{24'sd0, -24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd270},
		'{24'sd1, 24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd45},
		'{-24'sd1, 24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd135},
		'{-24'sd1, -24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd225},
		'{24'sd1, -24'sd1, 24'sd0, 1'b1, 10'sd0, 9'd315},
		'{CMAX, 24'sd0, CMAX, 1'b1, -10'sd45, 9'd0},
		'{24'sd1, 24'sd0, -24'sd1, 1'b1, -10'sd315, 9'd0},
		'{CMIN, 24'sd0, 24'sd0, 1'b1, 10'sd0, 9'd180},
		'{24'sd0, CMIN, 24'sd0, 1'b1, 10'sd0, 9'd270},
		'{CMIN, CMIN, CMIN, 1'b0, 10'sd0, 9'd0},
		'{CMAX, CMAX, CMAX, 1'b0, 10'sd0, 9'd0},
		'{-24'sd2, 24'sd1, 24'sd0, 1'b0, 10'sd0, 9'd0},
		'{CMAX, 24'sd1, 24'sd0, 1'b0, 10'sd0, 9'd0},
		'{-CMAX, -24'sd1, CMIN, 1'b0, 10'sd0, 9'd0},
		'{24'sd1, CMAX, -24'sd1, 1'b0, 10'sd0, 9'd0},
		'{24'sd3, -24'sd4, 24'sd5, 1'b0, 10'sd0, 9'd0}
	};

	vector_to_yaw_pitch_unit #(.COMP_BITS(COMP_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Degree boundaries are found by exact integer comparison against the tangent table,
	// so the horizontal magnitude is compared in squared form and never rounded.
	function automatic angle_t yaw_pitch_of(comp_t x, comp_t y, comp_t z);
		angle_t       r;
		logic [23:0]  ax, ay, az;
		logic [63:0]  lhs, rhs;
		logic [127:0] zs, ts;
		logic [49:0]  hs;
		int           f, m, yaw, p, pitch;
		bit           ex;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		if (x == 0 && y == 0) begin
			yaw = 0;
			pitch = (z > 0) ? 90 : 270;
		end else begin
			if (ax == 0) begin
				f = 90;
				ex = 1'b1;
			end else begin
				f = 0;
				ex = (ay == 0);
				for (int k = 1; k < DEG_COUNT; k++) begin
					lhs = 64'(TANK[k]) * 64'(ax);
					rhs = 64'(ay) * 64'd10000000;
					if (lhs <= rhs) begin
						f = k;
						ex = (lhs == rhs);
					end
				end
			end
			m = (x >= 0) ? f : 180 - (f + (ex ? 0 : 1));
			yaw = (y < 0) ? -m : m;
			if (yaw < 0)
				yaw += 360;
			hs = 50'(ax) * 50'(ax) + 50'(ay) * 50'(ay);
			zs = 128'(az) * 128'(az) * 128'(64'd100000000000000);
			p = 0;
			for (int k = 1; k < DEG_COUNT; k++) begin
				ts = 128'(TANK[k]) * 128'(TANK[k]) * 128'(hs);
				if (ts <= zs)
					p = k;
			end
			pitch = (z < 0) ? -p : p;
			if (pitch < 0)
				pitch += 360;
		end
		r.pitch_neg = PITCH_W'(-pitch);
		r.yaw_deg = ANG_W'(yaw);
		return r;
	endfunction

	function automatic comp_t edge_value();
		case ($urandom_range(5))
			0: return 24'sd0;
			1: return 24'sd1;
			2: return -24'sd1;
			3: return CMAX;
			4: return CMIN;
			default: return comp_t'($urandom);
		endcase
	endfunction

	function automatic comp_t with_sign(longint v);
		return comp_t'($urandom_range(1) ? -v : v);
	endfunction

	// Nearly half of the vectors sit on or next to a degree boundary of yaw or pitch, where truncation errors show.
	function automatic void pick_vector(output comp_t x, output comp_t y, output comp_t z);
		int     mode, k, sh;
		longint mag, lim, other;
		real    h;
		mode = $urandom_range(99);
		x = comp_t'($urandom);
		y = comp_t'($urandom);
		z = comp_t'($urandom);
		if (mode < 28) begin
		end else if (mode < 42) begin
			x = comp_t'($urandom_range(8) - 4);
			y = comp_t'($urandom_range(8) - 4);
			z = comp_t'($urandom_range(8) - 4);
		end else if (mode < 62) begin
			k = $urandom_range(1, DEG_COUNT - 1);
			lim = (longint'(8388607) * 10000000) / longint'(TANK[k]);
			if (lim > 8388607)
				lim = 8388607;
			if ($urandom_range(1) && lim > 1000)
				lim = 1000;
			mag = $urandom_range(1, int'(lim));
			other = (mag * longint'(TANK[k]) + 5000000) / 10000000 + $urandom_range(2) - 1;
			if (other > 8388607)
				other = 8388607;
			if (other < 0)
				other = 0;
			x = with_sign(mag);
			y = with_sign(other);
		end else if (mode < 80) begin
			k = $urandom_range(1, DEG_COUNT - 1);
			sh = $urandom_range(1, 23);
			x = with_sign($urandom_range(0, (1 << sh) - 1));
			y = with_sign($urandom_range(0, (1 << sh) - 1));
			if (x == 0 && y == 0)
				x = 24'sd1;
			h = $sqrt(real'(x) * real'(x) + real'(y) * real'(y));
			other = longint'(h * real'(TANK[k]) / 1.0e7) + $urandom_range(2) - 1;
			if (other > 8388607)
				other = 8388607;
			if (other < 0)
				other = 0;
			z = with_sign(other);
		end else if (mode < 92) begin
			x = edge_value();
			y = edge_value();
			z = edge_value();
		end else begin
			mag = $urandom_range(1, 8388607);
			x = with_sign(mag);
			y = with_sign(mag);
			if ($urandom_range(1))
				z = with_sign(mag);
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
	endtask

	task automatic send_vector(comp_t x, comp_t y, comp_t z, angle_t want);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_angles.push_back(want);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_idle);

	always @(posedge clk) begin : watch_results
		angle_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_angles.size() == 0) begin
				report_mismatch("unexpected item, yaw", int'(m_tdata[ANG_W+PITCH_W-1:PITCH_W]), -1);
			end else begin
				want = pending_angles.pop_front();
				if (m_tdata[PITCH_W-1:0] !== want.pitch_neg)
					report_mismatch("pitch_neg", $signed(m_tdata[PITCH_W-1:0]), want.pitch_neg);
				if (m_tdata[ANG_W+PITCH_W-1:PITCH_W] !== want.yaw_deg)
					report_mismatch("yaw_deg", int'(m_tdata[ANG_W+PITCH_W-1:PITCH_W]),
						int'(want.yaw_deg));
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		comp_t  x, y, z;
		angle_t want;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		src_idle = 36;
		snk_idle = 50;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].known) begin
				want.pitch_neg = plan[i].pitch_neg;
				want.yaw_deg = plan[i].yaw_deg;
			end else begin
				want = yaw_pitch_of(plan[i].x, plan[i].y, plan[i].z);
			end
			send_vector(plan[i].x, plan[i].y, plan[i].z, want);
		end
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				src_idle = 50;
				snk_idle = 36;
			end
			if (n == 2 * RAND_ITEMS / 3) begin
				src_idle = 0;
				snk_idle = 0;
			end
			pick_vector(x, y, z);
			send_vector(x, y, z, yaw_pitch_of(x, y, z));
		end
		s_tvalid <= 1'b0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_angles.size() != 0)
			report_mismatch("results still missing", pending_angles.size(), 0);
		$display("Sent %0d directed and %0d random direction vectors under three flow-control mixes.",
			$size(plan), RAND_ITEMS);
		$display("Checked %0d yaw and pitch items against the predictor, %0d mismatches.",
			results_seen, errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
sv/vtyp_pkg.sv
sv/vtyp_prep.sv
sv/vtyp_step.sv
sv/vtyp_finish.sv
sv/vector_to_yaw_pitch_unit.sv
tb/sv/tb_vector_to_yaw_pitch_unit.sv
